### hdl/suk_pkg.sv
// shared types and constants for the sorted unique key table
package suk_pkg;

  localparam int KEY_W           = 32;
  localparam int POS_W           = 11;
  localparam int CFG_W           = 2;
  localparam int MAX_KEYS        = 2;
  localparam int ENTRIES_DEFAULT = 1024;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // probe key as seen by every cell of the row
  typedef struct packed {
    logic                    two_parts;
    logic signed [KEY_W-1:0] first;
    logic signed [KEY_W-1:0] second;
  } probe_t;

  // number of compared parts above one, after clamping to the supported range
  function automatic logic use_two_parts(input logic [CFG_W-1:0] keys_in_use);
    logic two;
    two = (keys_in_use >= CFG_W'(2));
    return two && (MAX_KEYS >= 2);
  endfunction

endpackage

### hdl/sorted_unique_key_table.sv
// Sorted unique key table: a row of ENTRIES cells keeps keys in ascending order. After start
// is taken, all cells compare the probe at once, then a binary search walks the registered
// compare bits one probe per cycle while busy stays high, and the insert shift into the row
// happens as the search finishes. The result appears for exactly one cycle with done in the
// cycle after busy falls, and must be captured then: there is no way to hold it. A new
// start may be given in that same cycle. Configuration writes are always ready and take
// effect on the next item.
module sorted_unique_key_table import suk_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic                    kind,
  input  logic signed [KEY_W-1:0] key_first,
  input  logic signed [KEY_W-1:0] key_second,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    done,
  output logic [POS_W-1:0]        position,
  output logic                    found,
  output logic                    inserted,
  output logic                    table_full
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CMP    = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [CFG_W-1:0] keys_in_use;
  logic [CW-1:0]    entry_count;
  logic [CW-1:0]    low;
  logic [CW-1:0]    high;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    low_m1;
  logic [CW-1:0]    pos_c;
  logic             kind_reg;
  probe_t           probe;
  logic             accept;
  logic             finishing;
  logic             found_c;
  logic             is_full;
  logic             write_en;

  logic signed [KEY_W-1:0] cell_first  [ENTRIES];
  logic signed [KEY_W-1:0] cell_second [ENTRIES];
  logic [ENTRIES-1:0]      ge_vec;
  logic [ENTRIES-1:0]      eq_vec;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    mid       = low + ((high - low) >> 1);
    low_m1    = low - CW'(1);
    finishing = (state == ST_SEARCH) && !(low < high);
    found_c   = (low != '0) && eq_vec[low_m1[IW-1:0]];
    pos_c     = found_c ? low_m1 : low;
    is_full   = (entry_count >= CW'(ENTRIES));
    write_en  = finishing && !found_c && (kind_reg == KIND_INSERT) && !is_full;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_CMP;
      ST_CMP:    state_next = ST_SEARCH;
      ST_SEARCH: if (finishing) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      keys_in_use <= CFG_W'(1);
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finishing;
      if (cfg_valid && cfg_ready) begin
        keys_in_use <= cfg_data;
      end
      if (write_en) begin
        entry_count <= entry_count + CW'(1);
      end
    end
  end

  // payload, search pointers and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_reg        <= kind;
      probe.first     <= key_first;
      probe.second    <= key_second;
      probe.two_parts <= use_two_parts(keys_in_use);
    end
    if (state == ST_CMP) begin
      low  <= '0;
      high <= entry_count;
    end else if (state == ST_SEARCH && low < high) begin
      if (ge_vec[mid[IW-1:0]]) begin
        low <= mid + CW'(1);
      end else begin
        high <= mid;
      end
    end
    if (finishing) begin
      position   <= POS_W'(pos_c);
      found      <= found_c;
      inserted   <= write_en;
      table_full <= !found_c && (kind_reg == KIND_INSERT) && is_full;
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      suk_cell #(.CW(CW), .IDX(i)) u_cell (
        .clk         (clk),
        .probe       (probe),
        .prev_first  (probe.first),
        .prev_second (probe.second),
        .write_en    (write_en),
        .pos         (pos_c),
        .key_first   (cell_first[i]),
        .key_second  (cell_second[i]),
        .ge          (ge_vec[i]),
        .eq          (eq_vec[i])
      );
    end else begin : g_rest
      suk_cell #(.CW(CW), .IDX(i)) u_cell (
        .clk         (clk),
        .probe       (probe),
        .prev_first  (cell_first[i-1]),
        .prev_second (cell_second[i-1]),
        .write_en    (write_en),
        .pos         (pos_c),
        .key_first   (cell_first[i]),
        .key_second  (cell_second[i]),
        .ge          (ge_vec[i]),
        .eq          (eq_vec[i])
      );
    end
  end

  a_done_after_search: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_SEARCH)
    else $error("result strobe without a finished search");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done && inserted |-> !found && !table_full)
    else $error("insert flagged together with found or full");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    done && inserted |-> entry_count == $past(entry_count) + CW'(1))
    else $error("entry count did not follow the insert");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    done && table_full |-> entry_count == CW'(ENTRIES))
    else $error("full reported with room left");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(ENTRIES))
    else $error("entry count beyond table size");

endmodule

### hdl/suk_cell.sv
// one table entry: holds a key, compares it with the probe, shifts up on insert
module suk_cell import suk_pkg::*; #(
  parameter int CW  = 11,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  probe_t                  probe,
  input  logic signed [KEY_W-1:0] prev_first,
  input  logic signed [KEY_W-1:0] prev_second,
  input  logic                    write_en,
  input  logic [CW-1:0]           pos,
  output logic signed [KEY_W-1:0] key_first,
  output logic signed [KEY_W-1:0] key_second,
  output logic                    ge,
  output logic                    eq
);

  logic gt_first;
  logic eq_first;
  logic ge_second;
  logic eq_second;
  logic ge_next;
  logic eq_next;

  always_comb begin
    gt_first  = probe.first > key_first;
    eq_first  = probe.first == key_first;
    ge_second = probe.second >= key_second;
    eq_second = probe.second == key_second;
    if (probe.two_parts) begin
      ge_next = gt_first | (eq_first & ge_second);
      eq_next = eq_first & eq_second;
    end else begin
      ge_next = gt_first | eq_first;
      eq_next = eq_first;
    end
  end

  always_ff @(posedge clk) begin
    ge <= ge_next;
    eq <= eq_next;
    if (write_en) begin
      if (pos == CW'(IDX)) begin
        key_first  <= probe.first;
        key_second <= probe.second;
      end else if (pos < CW'(IDX)) begin
        // entries above the insertion point move up by one
        key_first  <= prev_first;
        key_second <= prev_second;
      end
    end
  end

endmodule

### test/suk_checker.sv
// checker for the sorted unique key table: predicts every result and compares it
`timescale 1ns / 1ps

module suk_checker import suk_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    kind,
  input  logic signed [KEY_W-1:0] key_first,
  input  logic signed [KEY_W-1:0] key_second,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    done,
  input  logic [POS_W-1:0]        position,
  input  logic                    found,
  input  logic                    inserted,
  input  logic                    table_full,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             inserted;
    logic             table_full;
  } search_result_t;

  // shadow copy of the sorted row
  logic signed [KEY_W-1:0] row_first  [ENTRIES];
  logic signed [KEY_W-1:0] row_second [ENTRIES];
  int unsigned             row_count;
  logic [CFG_W-1:0]        parts_reg;
  search_result_t          awaiting[$];

  task automatic report_mismatch(input string msg);
    $display("%0t suk_checker: %s", $time, msg);
    fail_count++;
  endtask

  // -1, 0, 1 as the probe is below, equal to, above stored entry idx
  function automatic int order_of(input logic signed [KEY_W-1:0] f,
                                  input logic signed [KEY_W-1:0] s,
                                  input int unsigned idx, input bit both);
    if (f < row_first[idx]) return -1;
    if (f > row_first[idx]) return 1;
    if (!both) return 0;
    if (s < row_second[idx]) return -1;
    if (s > row_second[idx]) return 1;
    return 0;
  endfunction

  // upper-bound search, then insert into the shadow row when the key is new, the item is an insert and the row has room
  function automatic search_result_t place_key(input logic k,
                                               input logic signed [KEY_W-1:0] f,
                                               input logic signed [KEY_W-1:0] s);
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    int unsigned    at;
    int unsigned    i;
    bit             both;
    search_result_t r;
    both = (parts_reg > 1) && (MAX_KEYS > 1);
    lo = 0;
    hi = row_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (order_of(f, s, mid, both) >= 0) lo = mid + 1;
      else hi = mid;
    end
    r = '0;
    if (lo > 0 && order_of(f, s, lo - 1, both) == 0) begin
      r.found = 1'b1;
      at = lo - 1;
    end else begin
      at = lo;
      if (k == KIND_INSERT) begin
        if (row_count >= ENTRIES) begin
          r.table_full = 1'b1;
        end else begin
          for (i = row_count; i > at; i--) begin
            row_first[i]  = row_first[i-1];
            row_second[i] = row_second[i-1];
          end
          row_first[at]  = f;
          row_second[at] = s;
          row_count++;
          r.inserted = 1'b1;
        end
      end
    end
    r.position = POS_W'(at);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    search_result_t want;
    if (rst) begin
      row_count  = 0;
      parts_reg  = CFG_W'(1);
      awaiting.delete();
      pending    = 0;
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) parts_reg = cfg_data;
      if (done) begin
        if (awaiting.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding, position %0d", position));
        end else begin
          want = awaiting.pop_front();
          if (position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d", position, want.position));
          if (found !== want.found)
            report_mismatch($sformatf("found %b, expected %b", found, want.found));
          if (inserted !== want.inserted)
            report_mismatch($sformatf("inserted %b, expected %b", inserted, want.inserted));
          if (table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, expected %b", table_full,
                                      want.table_full));
        end
      end
      if (start && !busy) awaiting.push_back(place_key(kind, key_first, key_second));
      pending = awaiting.size();
    end
  end

endmodule

### test/sorted_unique_key_table_tb.sv
// testbench top for the sorted unique key table: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module sorted_unique_key_table_tb;
  import suk_pkg::*;

  localparam int TABLE_SIZE   = ENTRIES_DEFAULT;
  localparam int RANDOM_ITEMS = 1350;
  localparam int PHASE_ITEMS  = 200;
  localparam int STALL_LIMIT  = 400;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic                    kind;
  logic signed [KEY_W-1:0] key_first;
  logic signed [KEY_W-1:0] key_second;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_W-1:0]        cfg_data;
  logic                    done;
  logic [POS_W-1:0]        position;
  logic                    found;
  logic                    inserted;
  logic                    table_full;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int seen_inserts = 0;

  logic signed [KEY_W-1:0] sent_first[$];
  logic signed [KEY_W-1:0] sent_second[$];

  sorted_unique_key_table u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .key_first  (key_first),
    .key_second (key_second),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .position   (position),
    .found      (found),
    .inserted   (inserted),
    .table_full (table_full)
  );

  suk_checker #(.ENTRIES(TABLE_SIZE)) u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .key_first  (key_first),
    .key_second (key_second),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .position   (position),
    .found      (found),
    .inserted   (inserted),
    .table_full (table_full),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // any accepted transaction on any channel clears the stall count
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (done && inserted) seen_inserts <= seen_inserts + 1;
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("sorted_unique_key_table_tb: errors");
    $finish;
  end

  task automatic send_item(input logic k, input logic signed [KEY_W-1:0] f,
                           input logic signed [KEY_W-1:0] s, input int gap_pct);
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      start      <= 1'b0;
      kind       <= 1'($urandom_range(0, 1));
      key_first  <= $urandom;
      key_second <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    kind       <= k;
    key_first  <= f;
    key_second <= s;
    do @(posedge clk); while (busy);
    sent_first.push_back(f);
    sent_second.push_back(s);
  endtask

  task automatic write_keys_in_use(input logic [CFG_W-1:0] value);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [KEY_W-1:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      default: return 32'sh8000_0001;
    endcase
  endfunction

  // mostly fresh keys while the table fills, more repeats once it is full
  task automatic pick_key(input bit filled, output logic signed [KEY_W-1:0] f,
                          output logic signed [KEY_W-1:0] s);
    int roll;
    int idx;
    roll = $urandom_range(0, 99);
    idx  = $urandom_range(0, sent_first.size() - 1);
    f = $urandom;
    s = $urandom;
    if (filled) begin
      if (roll < 30) ;
      else if (roll < 45) f = sent_first[idx];
      else if (roll < 80) begin
        f = sent_first[idx];
        s = sent_second[idx];
      end else if (roll < 90) f = sent_first[idx] + ($urandom_range(0, 1) ? 1 : -1);
      else f = corner_value();
    end else begin
      if (roll < 72) ;
      else if (roll < 82) f = sent_first[idx];
      else if (roll < 90) begin
        f = sent_first[idx];
        s = sent_second[idx];
      end else if (roll < 96) f = sent_first[idx] + ($urandom_range(0, 1) ? 1 : -1);
      else begin
        f = corner_value();
        if ($urandom_range(0, 1)) s = corner_value();
      end
    end
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0]        cfg_plan [4];
    int                      gap_plan [3];
    int                      phase;
    int                      n_random;
    int                      full_items;
    int                      j;
    bit                      filled;
    logic                    k;
    logic signed [KEY_W-1:0] f;
    logic signed [KEY_W-1:0] s;

    cfg_plan = '{2'd2, 2'd0, 2'd3, 2'd1};
    gap_plan = '{0, 53, 8};
    rst        = 1'b1;
    start      = 1'b0;
    kind       = KIND_INSERT;
    key_first  = '0;
    key_second = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, one compared part as after reset
    send_item(KIND_LOOKUP, 32'sd0, 32'sd0, 0);
    send_item(KIND_INSERT, 32'sd0, 32'sd7, 0);
    send_item(KIND_INSERT, 32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_item(KIND_INSERT, 32'sh7fff_ffff, 32'sh8000_0000, 0);
    send_item(KIND_INSERT, -32'sd1, 32'sd0, 0);
    send_item(KIND_INSERT, 32'sd1, -32'sd1, 0);
    // second part differs but is not compared
    send_item(KIND_INSERT, 32'sd0, 32'sd99, 0);
    send_item(KIND_LOOKUP, 32'sd0, -32'sd5, 0);
    send_item(KIND_LOOKUP, 32'sd2, 32'sd0, 0);
    send_item(KIND_LOOKUP, 32'sh8000_0000, 32'sd0, 0);
    send_item(KIND_LOOKUP, 32'sh7fff_ffff, 32'sd0, 0);
    send_item(KIND_INSERT, 32'sh8000_0001, 32'sh5555_5555, 0);
    send_item(KIND_INSERT, 32'sh7fff_fffe, 32'shaaaa_aaaa, 0);
    send_item(KIND_LOOKUP, -32'sd2, 32'sd0, 0);
    send_item(KIND_INSERT, 32'sh7fff_ffff, 32'sd0, 0);
    send_item(KIND_LOOKUP, 32'sh8000_0001, 32'sd3, 0);
    send_item(KIND_INSERT, 32'sh5555_5555, 32'shffff_ffff, 0);
    send_item(KIND_INSERT, 32'shaaaa_aaaa, 32'sh0, 0);
    send_item(KIND_LOOKUP, 32'sh5555_5555, 32'sd1, 0);
    @(negedge clk);
    start <= 1'b0;

    phase      = 0;
    n_random   = 0;
    full_items = 0;
    while (n_random < RANDOM_ITEMS || full_items < 120) begin
      write_keys_in_use(cfg_plan[phase % 4]);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        filled = (seen_inserts >= TABLE_SIZE);
        if (filled) k = ($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_LOOKUP;
        else k = ($urandom_range(0, 99) < 92) ? KIND_INSERT : KIND_LOOKUP;
        pick_key(filled, f, s);
        send_item(k, f, s, gap_plan[phase % 3]);
        n_random++;
        if (filled) full_items++;
      end
      @(negedge clk);
      start <= 1'b0;
      phase++;
    end

    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_unique_key_table_tb: clean");
    end else begin
      $display("sorted_unique_key_table_tb: errors");
    end
    $finish;
  end

endmodule
